[rtl/core/gas_flow_mode_valve_pump_controller_assert.svh]
// assertion macros for the gas flow mode controller
`ifndef GAS_FLOW_MODE_VALVE_PUMP_CONTROLLER_ASSERT_SVH
`define GAS_FLOW_MODE_VALVE_PUMP_CONTROLLER_ASSERT_SVH

`ifndef SYNTH
`define GFC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gfc assertion failed");
`define GFC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gfc assertion failed");
`else
`define GFC_ASSERT_IMP(lbl, ante, cons)
`define GFC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/core/gfc_pkg.sv]
// types and codes shared by the gas flow mode controller
package gfc_pkg;

	localparam logic [2:0] MODE_XE_INLET  = 3'd0;
	localparam logic [2:0] MODE_AIR_INLET = 3'd1;
	localparam logic [2:0] MODE_LOOP      = 3'd2;
	localparam logic [2:0] MODE_PURGE     = 3'd3;
	localparam logic [2:0] MODE_POWERUP   = 3'd4;

	localparam logic [1:0] LVL_OFF  = 2'd0;
	localparam logic [1:0] LVL_MED  = 2'd1;
	localparam logic [1:0] LVL_FAST = 2'd2;

	localparam logic [1:0] FLOW_NONE  = 2'd0;
	localparam logic [1:0] FLOW_XENON = 2'd1;
	localparam logic [1:0] FLOW_ATMOS = 2'd2;

	localparam logic [15:0] VENT_TICKS_RESET = 16'd150;

	typedef struct packed {
		logic        xin_n;
		logic        air_n;
		logic        circ_n;
		logic        vent_n;
		logic        inlet_btn_n;
		logic        circ_btn_n;
	} gfc_poll_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic        circ_on;
		logic        circ_prev;
		logic [15:0] vent_count;
		logic [1:0]  flow;
		logic        inlet_valve;
		logic        circ_valve;
		logic [1:0]  inlet_pump;
		logic [1:0]  circ_pump;
	} gfc_state_t;

endpackage

[rtl/core/gfc_step.sv]
// next-state logic for one poll tick of the gas flow mode controller
module gfc_step import gfc_pkg::*; (
	input  gfc_state_t  cur,
	input  gfc_poll_t   poll,
	input  logic [15:0] vent_ticks,
	output gfc_state_t  nxt
);

	logic [2:0] pick;
	logic       pick_ok;
	logic       inlet_pressed;
	logic       circ_pressed;
	logic       keep_circ;

	assign inlet_pressed = ~poll.inlet_btn_n;
	assign circ_pressed  = ~poll.circ_btn_n;
	assign keep_circ     = (cur.mode == MODE_LOOP) ? cur.circ_on : 1'b0;

	always_comb begin
		pick_ok = 1'b1;
		pick    = MODE_POWERUP;
		priority if (!poll.xin_n) begin
			pick = MODE_XE_INLET;
		end else if (!poll.air_n) begin
			pick = MODE_AIR_INLET;
		end else if (!poll.circ_n) begin
			pick = MODE_LOOP;
		end else if (!poll.vent_n) begin
			pick = MODE_PURGE;
		end else begin
			pick_ok = 1'b0;
		end
	end

	always_comb begin
		nxt = cur;
		if (cur.vent_count != 16'd0) begin
			// vent phase, switches and inlet button ignored; circ button sampled on the last tick
			nxt.vent_count = cur.vent_count - 16'd1;
			if (cur.vent_count == 16'd1) begin
				nxt.inlet_pump = LVL_OFF;
				nxt.circ_on    = 1'b0;
				nxt.circ_prev  = circ_pressed;
			end
		end else begin
			if (pick_ok && (pick != cur.mode)) begin
				unique case (pick)
					MODE_XE_INLET, MODE_AIR_INLET: begin
						nxt.flow        = (pick == MODE_XE_INLET) ? FLOW_XENON : FLOW_ATMOS;
						nxt.inlet_valve = (pick == MODE_XE_INLET);
						nxt.inlet_pump  = LVL_OFF;
						nxt.circ_on     = keep_circ;
						nxt.circ_valve  = keep_circ;
						nxt.circ_pump   = keep_circ ? LVL_MED : LVL_OFF;
					end
					MODE_LOOP: begin
						nxt.inlet_valve = 1'b0;
						nxt.inlet_pump  = LVL_OFF;
						nxt.circ_on     = 1'b0;
						nxt.circ_valve  = 1'b0;
						nxt.circ_pump   = LVL_OFF;
					end
					default: begin
						nxt.flow        = FLOW_NONE;
						nxt.inlet_valve = 1'b0;
						nxt.circ_valve  = 1'b1;
						nxt.circ_pump   = LVL_MED;
						nxt.inlet_pump  = LVL_FAST;
						nxt.vent_count  = (vent_ticks != 16'd0) ? vent_ticks : 16'd1;
					end
				endcase
				nxt.mode = pick;
			end
			if (nxt.vent_count == 16'd0) begin
				if (nxt.mode == MODE_AIR_INLET) begin
					nxt.inlet_pump = inlet_pressed ? LVL_MED : LVL_OFF;
				end
				// toggle on press after release
				if (circ_pressed && !cur.circ_prev && (nxt.mode != MODE_PURGE)) begin
					nxt.circ_on    = ~nxt.circ_on;
					nxt.circ_valve = nxt.circ_on;
					nxt.circ_pump  = nxt.circ_on ? LVL_MED : LVL_OFF;
				end
				nxt.circ_prev = circ_pressed;
			end
		end
	end

endmodule

[rtl/core/gas_flow_mode_valve_pump_controller.sv]
// top level of the gas flow mode, valve and pump controller
// Each request on the input channel (in_valid/in_ready) is one poll tick carrying
// the four active-low mode switches and the two active-low buttons. Every request
// yields exactly one result on the output channel (out_valid/out_ready): valve
// drives, pump levels, flow type, current mode and the vent busy flag.
// A request is captured in an input register, the next state is formed by one
// level of logic and lands in the mode state and the result register together,
// so a result passes the input register and then the result register, and one
// request is taken per cycle for as long as the receiver keeps up.
// When the receiver stalls, the result register holds and the input register
// keeps one more request; after that in_ready drops until out_ready returns.
// The vent length register is written through cfg_valid/cfg_ready/cfg_data,
// which is always ready; write it only while no request is in flight.
// Reset puts the block in start mode with valves closed, pumps off, flow type
// reset, no vent running and the vent length at 150 ticks.
`include "gas_flow_mode_valve_pump_controller_assert.svh"

module gas_flow_mode_valve_pump_controller import gfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        xin_switch_n,
	input  logic        air_switch_n,
	input  logic        circ_switch_n,
	input  logic        vent_switch_n,
	input  logic        inlet_button_n,
	input  logic        circ_button_n,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        inlet_valve,
	output logic        circ_valve,
	output logic [1:0]  inlet_pump_level,
	output logic [1:0]  circ_pump_level,
	output logic [1:0]  flow_kind,
	output logic [2:0]  active_mode,
	output logic        venting_busy
);

	logic [15:0] vent_ticks_q;
	gfc_poll_t   poll_s1;
	logic        valid_s1;
	logic        adv_s1;
	gfc_state_t  st_q;
	gfc_state_t  st_nxt;
	logic        out_valid_q;
	logic        inlet_valve_q;
	logic        circ_valve_q;
	logic [1:0]  inlet_pump_q;
	logic [1:0]  circ_pump_q;
	logic [1:0]  flow_q;
	logic [2:0]  mode_q;
	logic        busy_q;

	assign cfg_ready = 1'b1;
	assign adv_s1    = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vent_ticks_q <= VENT_TICKS_RESET;
		end else if (cfg_valid) begin
			vent_ticks_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			poll_s1 <= '{xin_n: xin_switch_n, air_n: air_switch_n, circ_n: circ_switch_n,
				vent_n: vent_switch_n, inlet_btn_n: inlet_button_n,
				circ_btn_n: circ_button_n};
		end
	end

	gfc_step u_step (
		.cur        (st_q),
		.poll       (poll_s1),
		.vent_ticks (vent_ticks_q),
		.nxt        (st_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{mode: MODE_POWERUP, circ_on: 1'b0, circ_prev: 1'b0, vent_count: 16'd0,
				flow: FLOW_NONE, inlet_valve: 1'b0, circ_valve: 1'b0,
				inlet_pump: LVL_OFF, circ_pump: LVL_OFF};
		end else if (adv_s1) begin
			st_q <= st_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			inlet_valve_q <= st_nxt.inlet_valve;
			circ_valve_q  <= st_nxt.circ_valve;
			inlet_pump_q  <= st_nxt.inlet_pump;
			circ_pump_q   <= st_nxt.circ_pump;
			flow_q        <= st_nxt.flow;
			mode_q        <= st_nxt.mode;
			busy_q        <= (st_nxt.vent_count != 16'd0);
		end
	end

	assign out_valid        = out_valid_q;
	assign inlet_valve      = inlet_valve_q;
	assign circ_valve       = circ_valve_q;
	assign inlet_pump_level = inlet_pump_q;
	assign circ_pump_level  = circ_pump_q;
	assign flow_kind        = flow_q;
	assign active_mode      = mode_q;
	assign venting_busy     = busy_q;

	`GFC_ASSERT_IMP(a_busy_drives, out_valid_q && busy_q,
		(mode_q == MODE_PURGE) && (inlet_pump_q == LVL_FAST))
	`GFC_ASSERT_IMP(a_vent_mode, st_q.vent_count != 16'd0, st_q.mode == MODE_PURGE)
	`GFC_ASSERT_IMP(a_circ_pair, 1'b1,
		(st_q.circ_valve == (st_q.circ_pump == LVL_MED)) && (st_q.circ_pump != LVL_FAST))
	`GFC_ASSERT_IMP(a_xin_flow, st_q.mode == MODE_XE_INLET, st_q.flow == FLOW_XENON)
	`GFC_ASSERT_NXT(a_s1_held, valid_s1 && !adv_s1, valid_s1)

endmodule

[verif/tb_gas_flow_mode_valve_pump_controller.sv]
// self-checking testbench for the gas flow mode, valve and pump controller

typedef struct packed {
	logic       inlet_valve;
	logic       circ_valve;
	logic [1:0] inlet_pump;
	logic [1:0] circ_pump;
	logic [1:0] flow;
	logic [2:0] mode;
	logic       busy;
} gfc_drive_t;

class gfc_mode_scoreboard;
	logic [15:0] vent_len;
	logic [2:0]  cur_mode;
	logic        circ_enabled;
	logic        circ_btn_last;
	logic [15:0] vent_left;
	logic [1:0]  flow;
	logic        inlet_valve;
	logic        circ_valve;
	logic [1:0]  inlet_pump;
	logic [1:0]  circ_pump;
	gfc_drive_t  expected_drives[$];
	int          mismatches;
	int          results_seen;

	function new();
		vent_len      = gfc_pkg::VENT_TICKS_RESET;
		cur_mode      = gfc_pkg::MODE_POWERUP;
		circ_enabled  = 1'b0;
		circ_btn_last = 1'b0;
		vent_left     = '0;
		flow          = gfc_pkg::FLOW_NONE;
		inlet_valve   = 1'b0;
		circ_valve    = 1'b0;
		inlet_pump    = gfc_pkg::LVL_OFF;
		circ_pump     = gfc_pkg::LVL_OFF;
		mismatches    = 0;
		results_seen  = 0;
	endfunction

	function void set_vent_len(logic [15:0] v);
		vent_len = v;
	endfunction

	function bit busy();
		return vent_left != 0;
	endfunction

	function int pending();
		return expected_drives.size();
	endfunction

	function void circ_follow();
		circ_valve = circ_enabled;
		circ_pump  = circ_enabled ? gfc_pkg::LVL_MED : gfc_pkg::LVL_OFF;
	endfunction

	function void note_request(gfc_pkg::gfc_poll_t p);
		logic [2:0] pick;
		bit         picked;
		bit         inlet_pressed;
		bit         circ_pressed;
		gfc_drive_t d;
		inlet_pressed = !p.inlet_btn_n;
		circ_pressed  = !p.circ_btn_n;
		if (vent_left != 0) begin
			vent_left = vent_left - 16'd1;
			if (vent_left == 0) begin
				inlet_pump    = gfc_pkg::LVL_OFF;
				circ_enabled  = 1'b0;
				circ_btn_last = circ_pressed;
			end
		end else begin
			picked = 1'b1;
			pick   = gfc_pkg::MODE_POWERUP;
			if (!p.xin_n)
				pick = gfc_pkg::MODE_XE_INLET;
			else if (!p.air_n)
				pick = gfc_pkg::MODE_AIR_INLET;
			else if (!p.circ_n)
				pick = gfc_pkg::MODE_LOOP;
			else if (!p.vent_n)
				pick = gfc_pkg::MODE_PURGE;
			else
				picked = 1'b0;
			if (picked && pick != cur_mode) begin
				case (pick)
					gfc_pkg::MODE_XE_INLET, gfc_pkg::MODE_AIR_INLET: begin
						flow = (pick == gfc_pkg::MODE_XE_INLET) ? gfc_pkg::FLOW_XENON
							: gfc_pkg::FLOW_ATMOS;
						inlet_valve = (pick == gfc_pkg::MODE_XE_INLET);
						inlet_pump  = gfc_pkg::LVL_OFF;
						// circulation survives only when coming from circ mode
						if (cur_mode != gfc_pkg::MODE_LOOP)
							circ_enabled = 1'b0;
						circ_follow();
					end
					gfc_pkg::MODE_LOOP: begin
						inlet_valve  = 1'b0;
						inlet_pump   = gfc_pkg::LVL_OFF;
						circ_enabled = 1'b0;
						circ_follow();
					end
					default: begin
						flow        = gfc_pkg::FLOW_NONE;
						inlet_valve = 1'b0;
						circ_valve  = 1'b1;
						circ_pump   = gfc_pkg::LVL_MED;
						inlet_pump  = gfc_pkg::LVL_FAST;
						vent_left   = (vent_len != 0) ? vent_len : 16'd1;
					end
				endcase
				cur_mode = pick;
			end
			if (vent_left == 0) begin
				if (cur_mode == gfc_pkg::MODE_AIR_INLET)
					inlet_pump = inlet_pressed ? gfc_pkg::LVL_MED : gfc_pkg::LVL_OFF;
				if (circ_pressed && !circ_btn_last && cur_mode != gfc_pkg::MODE_PURGE) begin
					circ_enabled = !circ_enabled;
					circ_follow();
				end
				circ_btn_last = circ_pressed;
			end
		end
		d.inlet_valve = inlet_valve;
		d.circ_valve  = circ_valve;
		d.inlet_pump  = inlet_pump;
		d.circ_pump   = circ_pump;
		d.flow        = flow;
		d.mode        = cur_mode;
		d.busy        = (vent_left != 0);
		expected_drives.push_back(d);
	endfunction

	function string show(gfc_drive_t d);
		return $sformatf("iv=%0b cv=%0b ip=%0d cp=%0d flow=%0d mode=%0d busy=%0b",
			d.inlet_valve, d.circ_valve, d.inlet_pump, d.circ_pump, d.flow, d.mode,
			d.busy);
	endfunction

	function void check_result(gfc_drive_t got);
		gfc_drive_t want;
		bit         bad;
		results_seen++;
		if (expected_drives.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d with no pending request: %s", results_seen, show(got));
			return;
		end
		want = expected_drives.pop_front();
		bad = (got.inlet_valve !== want.inlet_valve) || (got.circ_valve !== want.circ_valve)
			|| (got.inlet_pump !== want.inlet_pump) || (got.circ_pump !== want.circ_pump)
			|| (got.flow !== want.flow) || (got.mode !== want.mode)
			|| (got.busy !== want.busy);
		if (bad) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d mismatch: expected %s, actual %s", results_seen,
					show(want), show(got));
		end
	endfunction
endclass

module tb_gas_flow_mode_valve_pump_controller;
	import gfc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam logic [5:0] DIRECTED_POLLS [24] = '{
		6'b111111, 6'b111110, 6'b111111, 6'b000000, 6'b011111, 6'b101101,
		6'b101111, 6'b110111, 6'b110110, 6'b110111, 6'b110110, 6'b110111,
		6'b110110, 6'b011110, 6'b110111, 6'b110110, 6'b101100, 6'b111011,
		6'b111010, 6'b111011, 6'b111010, 6'b111111, 6'b101110, 6'b111111
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	gfc_poll_t   poll = '1;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        inlet_valve;
	logic        circ_valve;
	logic [1:0]  inlet_pump_level;
	logic [1:0]  circ_pump_level;
	logic [1:0]  flow_kind;
	logic [2:0]  active_mode;
	logic        venting_busy;

	gfc_mode_scoreboard sb;
	int burst_left = 0;
	int counted = 0;
	int idle_cycles = 0;
	int rx_style = 0;
	int rx_left = 0;
	int rx_tick = 0;

	gas_flow_mode_valve_pump_controller u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.xin_switch_n     (poll.xin_n),
		.air_switch_n     (poll.air_n),
		.circ_switch_n    (poll.circ_n),
		.vent_switch_n    (poll.vent_n),
		.inlet_button_n   (poll.inlet_btn_n),
		.circ_button_n    (poll.circ_btn_n),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.inlet_valve      (inlet_valve),
		.circ_valve       (circ_valve),
		.inlet_pump_level (inlet_pump_level),
		.circ_pump_level  (circ_pump_level),
		.flow_kind        (flow_kind),
		.active_mode      (active_mode),
		.venting_busy     (venting_busy)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result({inlet_valve, circ_valve, inlet_pump_level, circ_pump_level,
					flow_kind, active_mode, venting_busy});
			if (in_valid && in_ready)
				sb.note_request(poll);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver: switches between always ready, random, periodic and long stalls
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_style = $urandom_range(0, 3);
			rx_left  = $urandom_range(20, 200);
		end
		rx_left--;
		rx_tick++;
		case (rx_style)
			0: out_ready = 1'b1;
			1: out_ready = ($urandom_range(0, 3) != 0);
			2: out_ready = (rx_tick % 5) < 2;
			default: out_ready = (rx_tick % 24) == 0;
		endcase
	end

	function automatic gfc_poll_t next_poll(bit vent_ok);
		gfc_poll_t  p;
		logic [3:0] sw;
		int         kind;
		int         target;
		p    = poll;
		kind = $urandom_range(0, 9);
		if (sb.busy() || kind < 2) begin
			p = 6'($urandom);
		end else begin
			sw = {p.xin_n, p.air_n, p.circ_n, p.vent_n};
			if (kind < 6) begin
				target = $urandom_range(0, 3);
				sw = 4'($urandom);
				for (int i = 0; i < target; i++)
					sw[3 - i] = 1'b1;
				sw[3 - target] = 1'b0;
			end
			if (!vent_ok && sw[3:1] == 3'b111 && !sw[0] && sb.cur_mode != MODE_PURGE)
				sw[0] = 1'b1;
			{p.xin_n, p.air_n, p.circ_n, p.vent_n} = sw;
			p.inlet_btn_n = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 2) == 0)
				p.circ_btn_n = !p.circ_btn_n;
		end
		return p;
	endfunction

	task automatic push_item(gfc_poll_t p);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 12);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		burst_left--;
		counted++;
		poll = p;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic write_vent_len(logic [15:0] v);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_data  = v;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_vent_len(v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic run_phase(int n, bit long_vent);
		int        stop;
		bit        vented;
		gfc_poll_t p;
		stop   = counted + n;
		vented = 1'b0;
		while (counted < stop || sb.busy()) begin
			p = next_poll(!long_vent);
			// long vent phase: one forced vent entry halfway through
			if (long_vent && !vented && sb.cur_mode != MODE_PURGE && counted >= stop - n / 2) begin
				{p.xin_n, p.air_n, p.circ_n, p.vent_n} = 4'b1110;
				vented = 1'b1;
			end
			push_item(p);
		end
	endtask

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED_POLLS[i]) begin
			push_item(DIRECTED_POLLS[i]);
			while (sb.busy())
				push_item(next_poll(1'b0));
		end

		write_vent_len(16'd1);
		run_phase(200, 1'b0);
		write_vent_len(16'd0);
		run_phase(120, 1'b0);
		write_vent_len(16'd300);
		run_phase(60, 1'b1);
		repeat (4) begin
			write_vent_len(16'($urandom_range(2, 40)));
			run_phase(120, 1'b0);
		end

		in_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (sb.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
